FILE: sv/chrl_pkg.sv
package chrl_pkg;

  // Ring table size; a lookup scans every slot once.
  localparam int RING_SLOTS = 16;
  localparam int IDX_W      = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int SLOT_W     = 4;
  localparam int RANGE_W    = 9;

  // Operation codes of an input beat.
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // MurmurHash3 x86_32 constants.
  localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MM_C2   = 32'h1b873593;
  localparam logic [31:0] MM_ADD  = 32'he6546b64;
  localparam logic [31:0] MM_LEN  = 32'h00000004;
  localparam logic [31:0] MM_F1   = 32'h85ebca6b;
  localparam logic [31:0] MM_F2   = 32'hc2b2ae35;

  // Hash sequencer steps, one register update each.
  typedef logic [2:0] hstep_t;
  localparam hstep_t HS_NONE    = 3'd0;
  localparam hstep_t HS_MUL_C1  = 3'd1;
  localparam hstep_t HS_MUL_C2  = 3'd2;
  localparam hstep_t HS_MIX     = 3'd3;
  localparam hstep_t HS_MUL_F1  = 3'd4;
  localparam hstep_t HS_MUL_F2  = 3'd5;
  localparam hstep_t HS_FOLD    = 3'd6;

  typedef struct packed {
    logic             load_key;
    logic             hash_en;
    hstep_t           hash_op;
    logic             wr_en;
    logic             scan_clr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             load_res;
  } chrl_cmd_t;

  typedef struct packed {
    logic out_hold;
  } chrl_sts_t;

endpackage

FILE: sv/chrl_dp.sv
module chrl_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  chrl_pkg::chrl_cmd_t cmd_i,
  output chrl_pkg::chrl_sts_t sts_o,
  input  logic [3:0]          slot_i,
  input  logic [31:0]         ring_position_i,
  input  logic                slot_valid_i,
  input  logic [31:0]         lookup_key_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [3:0]          node_slot_o,
  output logic [31:0]         key_hash_o,
  output logic                found_o
);
  import chrl_pkg::*;

  logic [31:0]           pos_mem [RING_SLOTS];
  logic [RING_SLOTS-1:0] live_q;
  logic [IDX_W-1:0]      wr_addr;

  logic [31:0]      h_q, h_d;
  logic [31:0]      mul_a, mul_b;
  logic [31:0]      mul_lo;
  logic [31:0]      rot13, mix_sum;

  logic             rd_vld_q;
  logic [31:0]      rd_pos_q;
  logic             rd_live_q;
  logic [IDX_W-1:0] rd_idx_q;

  logic             have_ge_q, have_min_q;
  logic [31:0]      ge_pos_q, min_pos_q;
  logic [IDX_W-1:0] ge_idx_q, min_idx_q;
  logic             upd_min, upd_ge;
  logic [IDX_W-1:0] pick;

  logic             out_vld_q;
  logic [SLOT_W-1:0] node_slot_q;
  logic [31:0]      key_hash_q;
  logic             found_q;

  assign wr_addr = IDX_W'(slot_i);

  // slot table: positions need no reset, live marks gate them
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      pos_mem[wr_addr] <= ring_position_i;
    end
    if (cmd_i.rd_en) begin
      rd_pos_q <= pos_mem[cmd_i.rd_addr];
      rd_live_q <= live_q[cmd_i.rd_addr];
      rd_idx_q <= cmd_i.rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        live_q[wr_addr] <= slot_valid_i;
      end
      rd_vld_q <= cmd_i.rd_en;
    end
  end

  // shared multiplier, low word only
  always_comb begin
    mul_a = h_q;
    mul_b = MM_C1;
    case (cmd_i.hash_op)
      HS_MUL_C1: begin
        mul_a = h_q;
        mul_b = MM_C1;
      end
      HS_MUL_C2: begin
        mul_a = (h_q << 15) | (h_q >> 17);
        mul_b = MM_C2;
      end
      HS_MUL_F1: begin
        mul_a = h_q;
        mul_b = MM_F1;
      end
      HS_MUL_F2: begin
        mul_a = h_q ^ (h_q >> 13);
        mul_b = MM_F2;
      end
      default: begin
        mul_a = h_q;
        mul_b = MM_C1;
      end
    endcase
  end

  assign mul_lo   = mul_a * mul_b;
  assign rot13    = (h_q << 13) | (h_q >> 19);
  assign mix_sum  = ((rot13 << 2) + rot13 + MM_ADD) ^ MM_LEN;

  always_comb begin
    h_d = h_q;
    case (cmd_i.hash_op)
      HS_MUL_C1, HS_MUL_C2, HS_MUL_F1, HS_MUL_F2: h_d = mul_lo;
      HS_MIX:  h_d = mix_sum ^ (mix_sum >> 16);
      HS_FOLD: h_d = h_q ^ (h_q >> 16);
      default: h_d = h_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_key) begin
      h_q <= lookup_key_i;
    end else if (cmd_i.hash_en) begin
      h_q <= h_d;
    end
  end

  // ascending scan with strict compares keeps the lowest slot on ties
  assign upd_min = rd_vld_q && rd_live_q && (!have_min_q || rd_pos_q < min_pos_q);
  assign upd_ge  = rd_vld_q && rd_live_q && (rd_pos_q >= h_q) &&
                   (!have_ge_q || rd_pos_q < ge_pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_ge_q  <= 1'b0;
      have_min_q <= 1'b0;
    end else if (cmd_i.scan_clr) begin
      have_ge_q  <= 1'b0;
      have_min_q <= 1'b0;
    end else begin
      if (upd_min) begin
        have_min_q <= 1'b1;
      end
      if (upd_ge) begin
        have_ge_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_min) begin
      min_pos_q <= rd_pos_q;
      min_idx_q <= rd_idx_q;
    end
    if (upd_ge) begin
      ge_pos_q <= rd_pos_q;
      ge_idx_q <= rd_idx_q;
    end
  end

  always_comb begin
    pick = '0;
    if (have_ge_q) begin
      pick = ge_idx_q;
    end else if (have_min_q) begin
      pick = min_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      node_slot_q <= SLOT_W'(pick);
      key_hash_q  <= h_q;
      found_q     <= have_min_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_res) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.out_hold = out_vld_q && out_stall_i;
  assign out_valid_o    = out_vld_q;
  assign node_slot_o    = node_slot_q;
  assign key_hash_o     = key_hash_q;
  assign found_o        = found_q;

endmodule

FILE: sv/chrl_ctrl.sv
module chrl_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                op_i,
  input  logic [3:0]          slot_i,
  output logic                in_stall_o,
  output chrl_pkg::chrl_cmd_t cmd_o,
  input  chrl_pkg::chrl_sts_t sts_i
);
  import chrl_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HASH = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_LAST = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_SLOTS - 1);

  logic [2:0]       state_q, state_d;
  hstep_t           step_q, step_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             accept;
  logic             in_range;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = {{(RANGE_W - SLOT_W){1'b0}}, slot_i} < RANGE_W'(RING_SLOTS);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.rd_addr = cnt_q;
    cmd_o.hash_op = HS_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept && op_i == OP_WRITE) begin
          cmd_o.wr_en = in_range;
        end
        if (accept && op_i == OP_LOOKUP) begin
          cmd_o.load_key = 1'b1;
          step_d  = HS_MUL_C1;
          state_d = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_en = 1'b1;
        cmd_o.hash_op = step_q;
        step_d = step_q + 3'd1;
        if (step_q == HS_FOLD) begin
          cmd_o.scan_clr = 1'b1;
          cnt_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_LAST;
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_LAST: begin
        // last slot is being compared this cycle
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_hold) begin
          cmd_o.load_res = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= HS_NONE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

FILE: sv/consistent_hash_ring_lookup_top.sv
// Consistent-hash ring lookup over a table of RING_SLOTS node slots.
// Input channel (in_valid_i / in_stall_o): one beat is either a slot write
// (op_i = 0: slot_i, ring_position_i, slot_valid_i) or a key lookup
// (op_i = 1: lookup_key_i). A write finishes in the accept cycle and gives
// no output beat; a write to a slot index beyond the table is dropped.
// A lookup hashes the key with MurmurHash3 x86_32 (seed 0) and returns the
// live slot with the smallest position at or above the hash, wrapping to
// the smallest position overall; ties go to the lowest slot. found_o = 0
// with node_slot_o = 0 means no slot is live.
// Output channel (out_valid_o / out_stall_i): one beat per lookup, held
// in an output register until taken.
// Timing: a lookup runs the hash steps on one shared 32x32 multiplier,
// then scans the slot memory through one read port, one slot a cycle,
// then drains the last compare (ST_LAST) and loads the result (ST_DONE)
// into the output register, raising out_valid_o; the next beat is taken in
// the cycle after the result is loaded. in_stall_o is low only when
// the sequencer is idle, so writes run at one beat per cycle. A result
// waiting under out_stall_i does not block new beats; a second lookup waits
// in its last cycle until the first is taken.
// Reset clears all live marks (empty table) and drops any pending result.
module consistent_hash_ring_lookup_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] ring_position_i,
  input  logic        slot_valid_i,
  input  logic [31:0] lookup_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  node_slot_o,
  output logic [31:0] key_hash_o,
  output logic        found_o
);
  import chrl_pkg::*;

  chrl_cmd_t cmd;
  chrl_sts_t sts;

  // sequencer: accept, hash steps, slot scan, result hand-off
  chrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .slot_i     (slot_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // slot table, hash unit, min/successor tracking, output register
  chrl_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .slot_i          (slot_i),
    .ring_position_i (ring_position_i),
    .slot_valid_i    (slot_valid_i),
    .lookup_key_i    (lookup_key_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .node_slot_o     (node_slot_o),
    .key_hash_o      (key_hash_o),
    .found_o         (found_o)
  );

endmodule

FILE: sim/testbench.sv
module testbench;
  import chrl_pkg::*;

  // Cycles with no beat moving on either channel before the run is called hung.
  // Worst correct stretch is a long receiver hold-off plus one lookup.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_BEATS   = 1250;
  localparam int HOT_KEYS       = 8;

  typedef struct {
    logic        op;
    logic [3:0]  slot;
    logic [31:0] pos;
    logic        live;
    logic [31:0] key;
    bit          drain;   // hold this beat back until no lookup is in flight
  } ring_beat_t;

  typedef struct {
    logic [3:0]  node_slot;
    logic [31:0] key_hash;
    logic        found;
  } ring_hit_t;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_e;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic        op_i            = OP_WRITE;
  logic [3:0]  slot_i          = '0;
  logic [31:0] ring_position_i = '0;
  logic        slot_valid_i    = 1'b0;
  logic [31:0] lookup_key_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [3:0]  node_slot_o;
  logic [31:0] key_hash_o;
  logic        found_o;

  consistent_hash_ring_lookup_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .slot_i          (slot_i),
    .ring_position_i (ring_position_i),
    .slot_valid_i    (slot_valid_i),
    .lookup_key_i    (lookup_key_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .node_slot_o     (node_slot_o),
    .key_hash_o      (key_hash_o),
    .found_o         (found_o)
  );

  // Beats waiting to be offered, and lookup results still owed by the block.
  ring_beat_t  pending_beats[$];
  ring_hit_t   owed_hits[$];

  // Shadow copy of the ring table, updated as write beats are accepted.
  logic [31:0] ring_pos  [RING_SLOTS];
  logic        ring_live [RING_SLOTS];

  int outstanding;   // owed_hits depth, published by nonblocking update
  int beats_in;      // input beats accepted so far
  int mismatches;
  int burst_left;
  int gap_left;
  int hold_left;
  int holds_done;
  int rx_left;
  rx_mode_e rx_mode;
  int idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // MurmurHash3 x86_32 of one 32-bit little-endian word, seed 0.
  function automatic logic [31:0] murmur_key(input logic [31:0] key);
    logic [31:0] k;
    logic [31:0] h;
    k = key * 32'hcc9e2d51;
    k = {k[16:0], k[31:17]};
    k = k * 32'h1b873593;
    h = k;
    h = {h[18:0], h[31:19]};
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // Owner of a key: first live slot clockwise from the hash, wrapping to the
  // lowest position; strict compares keep the lowest slot on a tie.
  function automatic ring_hit_t route_key(input logic [31:0] key);
    ring_hit_t   hit;
    logic        have_ge;
    logic        have_min;
    logic [31:0] ge_pos;
    logic [31:0] min_pos;
    logic [3:0]  ge_slot;
    logic [3:0]  min_slot;
    hit.key_hash = murmur_key(key);
    have_ge  = 1'b0;
    have_min = 1'b0;
    ge_pos   = '0;
    min_pos  = '0;
    ge_slot  = '0;
    min_slot = '0;
    for (int s = 0; s < RING_SLOTS; s++) begin
      if (ring_live[s]) begin
        if (!have_min || ring_pos[s] < min_pos) begin
          have_min = 1'b1;
          min_pos  = ring_pos[s];
          min_slot = s[3:0];
        end
        if (ring_pos[s] >= hit.key_hash && (!have_ge || ring_pos[s] < ge_pos)) begin
          have_ge = 1'b1;
          ge_pos  = ring_pos[s];
          ge_slot = s[3:0];
        end
      end
    end
    hit.found     = have_min;
    hit.node_slot = have_ge ? ge_slot : (have_min ? min_slot : 4'd0);
    return hit;
  endfunction

  // Beat builders; fields the operation ignores get random junk.
  function automatic ring_beat_t slot_write(input logic [3:0] slot, input logic [31:0] pos,
                                            input logic live);
    ring_beat_t b;
    b.op    = OP_WRITE;
    b.slot  = slot;
    b.pos   = pos;
    b.live  = live;
    b.key   = $urandom;
    b.drain = 1'b0;
    return b;
  endfunction

  function automatic ring_beat_t key_lookup(input logic [31:0] key);
    ring_beat_t b;
    b.op    = OP_LOOKUP;
    b.slot  = 4'($urandom_range(0, 15));
    b.pos   = $urandom;
    b.live  = 1'($urandom_range(0, 1));
    b.key   = key;
    b.drain = 1'b0;
    return b;
  endfunction

  // Driver: bursts of random length separated by random gaps. A beat stays
  // on the port until it is accepted.
  always @(posedge clk_i or negedge rst_ni) begin : drive_beats
    ring_beat_t beat;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_beats.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (pending_beats[0].drain && (in_valid_i || outstanding != 0)) begin
        // idle until the last accepted lookup has been answered
        in_valid_i <= 1'b0;
      end else begin
        beat = pending_beats.pop_front();
        in_valid_i      <= 1'b1;
        op_i            <= beat.op;
        slot_i          <= beat.slot;
        ring_position_i <= beat.pos;
        slot_valid_i    <= beat.live;
        lookup_key_i    <= beat.key;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 7))
            0, 1, 2: gap_left = 0;
            7:       gap_left = $urandom_range(13, 40);
            default: gap_left = $urandom_range(1, 12);
          endcase
        end
      end
    end
  end

  // Receiver: stall pattern changes after a random stretch; twice in the run
  // it holds off for a long stretch so a second lookup backs up the input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left  = 0;
      holds_done = 0;
      rx_left    = 0;
      rx_mode    = RX_OPEN;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if ((holds_done == 0 && beats_in >= 300) || (holds_done == 1 && beats_in >= 900)) begin
      hold_left  = HOLD_CYCLES;
      holds_done = holds_done + 1;
      out_stall_i <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 64);
      end else begin
        rx_left = rx_left - 1;
      end
      case (rx_mode)
        RX_LIGHT:  out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:  out_stall_i <= ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_stall_i <= ~out_stall_i;
        default:   out_stall_i <= 1'b0;
      endcase
    end
  end

  // Monitor: checks each result beat against the oldest owed lookup, then
  // folds the input beat of this edge into the shadow table.
  always @(posedge clk_i or negedge rst_ni) begin : watch_ports
    ring_hit_t want;
    if (!rst_ni) begin
      for (int s = 0; s < RING_SLOTS; s++) begin
        ring_pos[s]  = '0;
        ring_live[s] = 1'b0;
      end
      outstanding <= 0;
      beats_in    <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (owed_hits.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("unexpected result beat: slot %0d hash %h found %b",
                     node_slot_o, key_hash_o, found_o);
        end else begin
          want = owed_hits.pop_front();
          if (node_slot_o !== want.node_slot || key_hash_o !== want.key_hash ||
              found_o !== want.found) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display({"result mismatch: want slot %0d hash %h found %b, ",
                        "got slot %0d hash %h found %b"},
                       want.node_slot, want.key_hash, want.found,
                       node_slot_o, key_hash_o, found_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        beats_in <= beats_in + 1;
        if (op_i == OP_LOOKUP) begin
          owed_hits.push_back(route_key(lookup_key_i));
        end else if (slot_i < RING_SLOTS) begin
          ring_pos[slot_i]  = ring_position_i;
          ring_live[slot_i] = slot_valid_i;
        end
      end
      outstanding <= owed_hits.size();
    end
  end

  // Watchdog on stretches where neither channel moves a beat.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] k1;
    logic [31:0] h1;
    logic [31:0] k2;
    logic [31:0] h2;
    logic [31:0] hot_key  [HOT_KEYS];
    logic [31:0] hot_hash [HOT_KEYS];
    logic [31:0] tie_pos  [4];
    logic [31:0] pos;
    ring_beat_t  b;
    int          n;
    mismatches  = 0;
    idle_cycles = 0;

    // K1 hashes into the lower half, K2 above it: one exact hit, one wrap.
    do begin
      k1 = $urandom;
      h1 = murmur_key(k1);
    end while (h1[31]);
    do begin
      k2 = $urandom;
      h2 = murmur_key(k2);
    end while (h2 <= h1);

    // Directed: empty table, extreme positions, exact hit, tie, wrap, removal.
    pending_beats.push_back(key_lookup(32'h0000_0000));
    pending_beats.push_back(key_lookup(32'hffff_ffff));
    pending_beats.push_back(slot_write(4'd15, 32'hffff_ffff, 1'b1));
    pending_beats.push_back(key_lookup($urandom));
    pending_beats.push_back(slot_write(4'd0, 32'h0000_0000, 1'b1));
    pending_beats.push_back(key_lookup($urandom));
    pending_beats.push_back(slot_write(4'd7, h1, 1'b1));
    pending_beats.push_back(key_lookup(k1));
    pending_beats.push_back(slot_write(4'd3, h1, 1'b1));
    pending_beats.push_back(key_lookup(k1));
    pending_beats.push_back(slot_write(4'd15, $urandom, 1'b0));
    pending_beats.push_back(key_lookup(k2));
    pending_beats.push_back(slot_write(4'd0, $urandom, 1'b0));
    pending_beats.push_back(key_lookup(k2));
    b = key_lookup(32'h0000_0000);
    b.slot = 4'hf;
    b.pos  = 32'hffff_ffff;
    b.live = 1'b1;
    pending_beats.push_back(b);
    b = slot_write(4'd3, 32'h0000_0000, 1'b0);
    b.key = 32'hffff_ffff;
    pending_beats.push_back(b);
    pending_beats.push_back(slot_write(4'd7, $urandom, 1'b0));
    pending_beats.push_back(key_lookup(32'hffff_ffff));
    pending_beats.push_back(slot_write(4'd1, 32'h0000_0000, 1'b1));
    pending_beats.push_back(key_lookup(32'h0000_0000));
    pending_beats.push_back(key_lookup(k1));

    // Random part: positions cluster around the hashes of a few hot keys so
    // exact hits, near misses and wraps are common.
    for (int i = 0; i < HOT_KEYS; i++) begin
      hot_key[i]  = $urandom;
      hot_hash[i] = murmur_key(hot_key[i]);
    end
    for (int i = 0; i < 4; i++)
      tie_pos[i] = $urandom;

    n = 0;
    while (n < RANDOM_BEATS) begin
      if (n % 400 == 200) begin
        // clear the whole table so empty-table lookups recur
        for (int s = 0; s < 16; s++)
          pending_beats.push_back(slot_write(s[3:0], $urandom, 1'b0));
        n = n + 16;
      end
      if ($urandom_range(0, 99) < 60) begin
        if ($urandom_range(0, 9) < 4)
          b = key_lookup(hot_key[$urandom_range(0, HOT_KEYS - 1)]);
        else
          b = key_lookup($urandom);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2: pos = $urandom;
          3:       pos = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0000_0000;
          4, 5:    pos = tie_pos[$urandom_range(0, 3)];
          default: pos = hot_hash[$urandom_range(0, HOT_KEYS - 1)] + $urandom_range(0, 2) - 1;
        endcase
        b = slot_write(4'($urandom_range(0, 15)), pos, $urandom_range(0, 3) != 0);
      end
      if (n % 250 == 0)
        b.drain = 1'b1;
      pending_beats.push_back(b);
      n = n + 1;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample away from the active edge so the driver's last pop is settled.
    while (pending_beats.size() != 0 || in_valid_i || outstanding != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    if (owed_hits.size() != 0)
      $display("%0d lookup results never arrived", owed_hits.size());
    if (mismatches == 0 && owed_hits.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
